### hdl/b64_pkg.sv
// b64_pkg: shared types, constants and alphabet functions of the base64 codec
// depends on nothing; used by b64_core, b64_emit and base64_codec_stream
package b64_pkg;

	// decode end status codes
	localparam logic [1:0] CAUSE_CLEAN   = 2'd0;
	localparam logic [1:0] CAUSE_PAD     = 2'd1;
	localparam logic [1:0] CAUSE_INVALID = 2'd2;

	// direction register values
	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	localparam logic [7:0] CHAR_PAD = 8'h3d;

	// results of one input item, at most four
	typedef struct packed {
		logic [3:0][7:0] data;
		logic [2:0]      cnt;
		logic            bv;
		logic            fin;
		logic [1:0]      cause;
	} burst_t;

	// six-bit value to alphabet character
	function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
		logic [7:0] c;
		begin
			if (v < 6'd26) c = 8'(8'h41 + {2'b00, v});
			else if (v < 6'd52) c = 8'(8'h61 + {2'b00, v} - 8'd26);
			else if (v < 6'd62) c = 8'(8'h30 + {2'b00, v} - 8'd52);
			else if (v == 6'd62) c = 8'h2b;
			else c = 8'h2f;
			return c;
		end
	endfunction

	// character to six-bit value; bit 6 set for a character outside the alphabet
	function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
		logic [6:0] v;
		begin
			if (c >= 8'h41 && c <= 8'h5a) v = 7'(c - 8'h41);
			else if (c >= 8'h61 && c <= 8'h7a) v = 7'(c - 8'h61 + 8'd26);
			else if (c >= 8'h30 && c <= 8'h39) v = 7'(c - 8'h30 + 8'd52);
			else if (c == 8'h2b) v = 7'd62;
			else if (c == 8'h2f) v = 7'd63;
			else v = 7'd64;
			return v;
		end
	endfunction

endpackage

### hdl/b64_core.sv
// b64_core: input register, group state and the per-item encode/decode logic
// depends on b64_pkg; produces at most one burst of results per item for b64_emit
module b64_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              src_valid,
	output logic              src_stall,
	input  logic              has_byte,
	input  logic [7:0]        in_byte,
	input  logic              end_of_data,
	input  logic              take_ok,
	output logic              burst_load,
	output b64_pkg::burst_t   burst
);

	logic        valid_s1;
	logic        has_s1;
	logic [7:0]  byte_s1;
	logic        eod_s1;

	logic        dir_q;
	logic [17:0] gb_q;
	logic [1:0]  gc_q;
	logic        halted_q;
	logic [1:0]  reason_q;

	logic [17:0] gb_n;
	logic [1:0]  gc_n;
	logic        halted_n;
	logic [1:0]  reason_n;
	logic [23:0] g24;
	logic [6:0]  sx;
	logic        consume;

	// item leaves the input register when the emitter can take its burst or it has no results
	assign consume    = valid_s1 && (take_ok || (burst.cnt == 3'd0));
	assign src_stall  = valid_s1 && !consume;
	assign burst_load = consume && (burst.cnt != 3'd0);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_valid && !src_stall) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			has_s1  <= has_byte;
			byte_s1 <= in_byte;
			eod_s1  <= end_of_data;
		end
	end

	// group update and result burst for the item in the input register
	always_comb begin
		gb_n        = gb_q;
		gc_n        = gc_q;
		halted_n    = halted_q;
		reason_n    = reason_q;
		g24         = '0;
		sx          = b64_pkg::char_to_sextet(byte_s1);
		burst       = '0;
		burst.bv    = 1'b1;
		if (dir_q == b64_pkg::DIR_ENCODE) begin
			if (has_s1) begin
				if (gc_q == 2'd2) begin
					g24 = {gb_q[15:0], byte_s1};
					burst.data[0] = b64_pkg::sextet_to_char(g24[23:18]);
					burst.data[1] = b64_pkg::sextet_to_char(g24[17:12]);
					burst.data[2] = b64_pkg::sextet_to_char(g24[11:6]);
					burst.data[3] = b64_pkg::sextet_to_char(g24[5:0]);
					burst.cnt     = 3'd4;
					gb_n = '0;
					gc_n = 2'd0;
				end else begin
					gb_n = {gb_q[9:0], byte_s1};
					gc_n = 2'(gc_q + 2'd1);
				end
			end
			// partial group at end: characters then padding
			if (eod_s1 && gc_n != 2'd0) begin
				if (gc_n == 2'd1) g24 = {gb_n[7:0], 16'h0000};
				else g24 = {gb_n[15:0], 8'h00};
				burst.data[0] = b64_pkg::sextet_to_char(g24[23:18]);
				burst.data[1] = b64_pkg::sextet_to_char(g24[17:12]);
				burst.data[2] = (gc_n == 2'd1) ? b64_pkg::CHAR_PAD
					: b64_pkg::sextet_to_char(g24[11:6]);
				burst.data[3] = b64_pkg::CHAR_PAD;
				burst.cnt     = 3'd4;
			end
		end else begin
			if (has_s1 && !halted_q) begin
				if (byte_s1 == b64_pkg::CHAR_PAD) begin
					halted_n = 1'b1;
					reason_n = b64_pkg::CAUSE_PAD;
				end else if (sx[6]) begin
					halted_n = 1'b1;
					reason_n = b64_pkg::CAUSE_INVALID;
				end else if (gc_q == 2'd3) begin
					g24 = {gb_q, sx[5:0]};
					burst.data[0] = g24[23:16];
					burst.data[1] = g24[15:8];
					burst.data[2] = g24[7:0];
					burst.cnt     = 3'd3;
					gb_n = '0;
					gc_n = 2'd0;
				end else begin
					gb_n = {gb_q[11:0], sx[5:0]};
					gc_n = 2'(gc_q + 2'd1);
				end
			end
			// partial group at end: flush whole bytes, single character dropped
			if (eod_s1 && gc_n == 2'd2) begin
				burst.data[0] = gb_n[11:4];
				burst.cnt     = 3'd1;
			end else if (eod_s1 && gc_n == 2'd3) begin
				burst.data[0] = gb_n[17:10];
				burst.data[1] = gb_n[9:2];
				burst.cnt     = 3'd2;
			end
		end
		// end of message: last mark, stop cause, empty marker if nothing to send
		if (eod_s1) begin
			if (burst.cnt == 3'd0) begin
				burst.cnt = 3'd1;
				burst.bv  = 1'b0;
			end
			burst.fin   = 1'b1;
			burst.cause = (dir_q == b64_pkg::DIR_DECODE) ? reason_n : b64_pkg::CAUSE_CLEAN;
			gb_n     = '0;
			gc_n     = 2'd0;
			halted_n = 1'b0;
			reason_n = b64_pkg::CAUSE_CLEAN;
		end
	end

	// direction register and group state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q    <= b64_pkg::DIR_ENCODE;
			gb_q     <= '0;
			gc_q     <= 2'd0;
			halted_q <= 1'b0;
			reason_q <= b64_pkg::CAUSE_CLEAN;
		end else if (cfg_we) begin
			dir_q    <= cfg_wdata;
			gb_q     <= '0;
			gc_q     <= 2'd0;
			halted_q <= 1'b0;
			reason_q <= b64_pkg::CAUSE_CLEAN;
		end else if (consume) begin
			gb_q     <= gb_n;
			gc_q     <= gc_n;
			halted_q <= halted_n;
			reason_q <= reason_n;
		end
	end

endmodule

### hdl/b64_emit.sv
// b64_emit: result register holding one burst, sent one result per transfer
// depends on b64_pkg; fed by b64_core
module b64_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              burst_load,
	input  b64_pkg::burst_t   burst,
	output logic              take_ok,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [7:0]        out_byte,
	output logic              byte_valid,
	output logic              last,
	output logic [1:0]        stop_cause
);

	b64_pkg::burst_t buf_q;
	logic            busy_q;
	logic [1:0]      idx_q;
	logic            at_end;
	logic            xfer;

	assign at_end  = ({1'b0, idx_q} == 3'(buf_q.cnt - 3'd1));
	assign xfer    = busy_q && !res_stall;
	assign take_ok = !busy_q || (xfer && at_end);

	// result fields of the current entry
	assign res_valid  = busy_q;
	assign out_byte   = buf_q.data[idx_q];
	assign byte_valid = buf_q.bv;
	assign last       = buf_q.fin && at_end;
	assign stop_cause = (buf_q.fin && at_end) ? buf_q.cause : b64_pkg::CAUSE_CLEAN;

	// burst load and entry walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (burst_load) begin
			busy_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (xfer) begin
			if (at_end) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= 2'(idx_q + 2'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (burst_load) begin
			buf_q <= burst;
		end
	end

	// a loaded burst always has at least one entry and the walk stays inside it
	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (buf_q.cnt != 3'd0 && buf_q.cnt <= 3'd4))
		else $error("burst with bad entry count");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ({1'b0, idx_q} < buf_q.cnt))
		else $error("entry index past burst end");

	// a new burst never overwrites one with results still pending
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		burst_load |-> (!busy_q || (!res_stall && at_end)))
		else $error("burst loaded over pending results");

	// an empty end marker is a lone final result
	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !buf_q.bv) |-> (buf_q.fin && buf_q.cnt == 3'd1))
		else $error("empty marker not a lone final result");

endmodule

### hdl/base64_codec_stream.sv
// base64_codec_stream: top level of the streaming base64 codec
// depends on b64_pkg, b64_core and b64_emit
//
// Streaming base64 codec, standard alphabet with '=' padding. cfg_wdata written with cfg_we
// selects encode (0) or decode (1) and drops any partial message; write it only while idle.
// Each accepted item passes the input register and its results (up to four) land in the
// result register, which sends one result per cycle while res_stall is low.
// A new item is accepted every cycle as long as the results of the previous one are drained
// by then, so the output port sets the rate: encoding gives four characters per three bytes,
// decoding one character per cycle. The final result of a message carries last and stop_cause;
// if nothing is left to send, a marker with byte_valid low comes alone.
module base64_codec_stream (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       src_valid,
	output logic       src_stall,
	input  logic       has_byte,
	input  logic [7:0] in_byte,
	input  logic       end_of_data,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       last,
	output logic [1:0] stop_cause
);

	b64_pkg::burst_t burst;
	logic            burst_load;
	logic            take_ok;

	// per-item logic
	b64_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.src_valid  (src_valid),
		.src_stall  (src_stall),
		.has_byte   (has_byte),
		.in_byte    (in_byte),
		.end_of_data(end_of_data),
		.take_ok    (take_ok),
		.burst_load (burst_load),
		.burst      (burst)
	);

	// result serializer
	b64_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.burst_load (burst_load),
		.burst      (burst),
		.take_ok    (take_ok),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.last       (last),
		.stop_cause (stop_cause)
	);

endmodule

### tb/base64_codec_stream_tb.sv
// base64_codec_stream_tb: self-checking bench for the streaming base64 codec
// depends on b64_pkg and base64_codec_stream; a scoreboard class predicts every result

// one result of the codec as it leaves the output port
typedef struct packed {
	logic [7:0] data;
	logic       bv;
	logic       fin;
	logic [1:0] cause;
} b64_result_t;

// mirrors the codec state and holds the results still owed by the block
class b64_scoreboard;
	b64_result_t pending[$];
	logic        dir;
	logic [23:0] grp_bits;
	int          grp_cnt;
	logic        halted;
	logic [1:0]  halt_why;
	logic [6:0]  char_val[256];
	string       alphabet;
	int          errors;
	int          checked;

	function new();
		alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
		for (int c = 0; c < 256; c++) char_val[c] = 7'd64;
		for (int v = 0; v < 64; v++) char_val[int'(alphabet[v])] = 7'(v);
		errors = 0;
		checked = 0;
		set_direction(b64_pkg::DIR_ENCODE);
	endfunction

	// a direction write also drops any partial message
	function void set_direction(logic d);
		dir = d;
		grp_bits = '0;
		grp_cnt = 0;
		halted = 1'b0;
		halt_why = b64_pkg::CAUSE_CLEAN;
	endfunction

	function b64_result_t data_result(logic [7:0] d);
		b64_result_t r;
		r = '{data: d, bv: 1'b1, fin: 1'b0, cause: b64_pkg::CAUSE_CLEAN};
		return r;
	endfunction

	// work out the results of one accepted input transfer
	function void note_item(logic has, logic [7:0] b, logic eod);
		b64_result_t outs[4];
		int          k;
		logic [23:0] g;
		logic [6:0]  v;
		k = 0;
		if (dir == b64_pkg::DIR_ENCODE) begin
			if (has) begin
				grp_bits = {grp_bits[15:0], b};
				grp_cnt++;
				if (grp_cnt == 3) begin
					for (int i = 0; i < 4; i++)
						outs[k++] = data_result(8'(alphabet[int'(grp_bits[23 - 6 * i -: 6])]));
					grp_bits = '0;
					grp_cnt = 0;
				end
			end
			// partial group: characters for the bits held, then padding
			if (eod && grp_cnt != 0) begin
				g = grp_bits << (8 * (3 - grp_cnt));
				for (int i = 0; i < 4; i++) begin
					if (i <= grp_cnt)
						outs[k++] = data_result(8'(alphabet[int'(g[23 - 6 * i -: 6])]));
					else
						outs[k++] = data_result(b64_pkg::CHAR_PAD);
				end
			end
		end else begin
			if (has && !halted) begin
				v = char_val[b];
				if (b == b64_pkg::CHAR_PAD) begin
					halted = 1'b1;
					halt_why = b64_pkg::CAUSE_PAD;
				end else if (v[6]) begin
					halted = 1'b1;
					halt_why = b64_pkg::CAUSE_INVALID;
				end else if (grp_cnt == 3) begin
					g = {grp_bits[17:0], v[5:0]};
					outs[k++] = data_result(g[23:16]);
					outs[k++] = data_result(g[15:8]);
					outs[k++] = data_result(g[7:0]);
					grp_bits = '0;
					grp_cnt = 0;
				end else begin
					grp_bits = {grp_bits[17:0], v[5:0]};
					grp_cnt++;
				end
			end
			// two or three characters left flush one or two bytes; one is dropped
			if (eod && grp_cnt >= 2) begin
				g = grp_bits << (6 * (4 - grp_cnt));
				for (int i = 0; i < grp_cnt - 1; i++)
					outs[k++] = data_result(g[23 - 8 * i -: 8]);
			end
		end
		// end of message: mark the final result, or send a bare marker
		if (eod) begin
			if (k == 0) begin
				outs[0] = '0;
				k = 1;
			end
			outs[k - 1].fin = 1'b1;
			outs[k - 1].cause = (dir == b64_pkg::DIR_DECODE) ? halt_why : b64_pkg::CAUSE_CLEAN;
			set_direction(dir);
		end
		for (int i = 0; i < k; i++) pending = {pending, outs[i]};
	endfunction

	// compare one output transfer with the oldest expectation
	function void check_out(logic [7:0] d, logic bv, logic fin, logic [1:0] cause);
		b64_result_t want;
		checked++;
		if (pending.size() == 0) begin
			$error("result with nothing expected: out_byte %h last %b", d, fin);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (d !== want.data) begin
			$error("out_byte: expected %h, got %h", want.data, d);
			errors++;
		end
		if (bv !== want.bv) begin
			$error("byte_valid: expected %b, got %b", want.bv, bv);
			errors++;
		end
		if (fin !== want.fin) begin
			$error("last: expected %b, got %b", want.fin, fin);
			errors++;
		end
		if (cause !== want.cause) begin
			$error("stop_cause: expected %0d, got %0d", want.cause, cause);
			errors++;
		end
	endfunction
endclass

module base64_codec_stream_tb;

	localparam int SETTLE      = 6;
	localparam int HOLD_CYCLES = 150;
	localparam int IDLE_LIMIT  = 1000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       src_valid = 1'b0;
	logic       src_stall;
	logic       has_byte = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       end_of_data = 1'b0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       last;
	logic [1:0] stop_cause;

	b64_scoreboard tracker;
	int items_in = 0;
	int settings = 0;
	int idle_cycles = 0;
	bit src_burst = 1'b0;
	int burst_left = 0;
	bit rcv_burst = 1'b0;
	int rcv_wait = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;

	base64_codec_stream u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.src_valid  (src_valid),
		.src_stall  (src_stall),
		.has_byte   (has_byte),
		.in_byte    (in_byte),
		.end_of_data(end_of_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.last       (last),
		.stop_cause (stop_cause)
	);

	always #2 clk = ~clk;

	// output side: check each transfer, then stall for a random number of cycles
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				tracker.check_out(out_byte, byte_valid, last, stop_cause);
				if ($urandom_range(0, 11) == 0) rcv_burst = !rcv_burst;
				rcv_wait = rcv_burst ? 0 : $urandom_range(0, 18);
			end
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (rcv_wait > 0) begin
				rcv_wait--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (src_valid && !src_stall) || (res_valid && !res_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d cycles without a transfer", idle_cycles);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// gap before the next input transfer, with stretches of back-to-back items
	function automatic int src_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) src_burst = !src_burst;
		return src_burst ? 0 : $urandom_range(0, 18);
	endfunction

	// offer one item and wait for its transfer
	task automatic send_item(input logic has, input logic [7:0] b, input logic eod);
		int gap;
		gap = src_gap();
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		has_byte <= has;
		in_byte <= b;
		end_of_data <= eod;
		do @(posedge clk); while (src_stall);
		tracker.note_item(has, b, eod);
		if (has || eod) items_in++;
	endtask

	task automatic send_string(input string s, input logic eod_last);
		for (int i = 0; i < s.len(); i++)
			send_item(1'b1, 8'(s[i]), eod_last && i == s.len() - 1);
	endtask

	// wait until every expected result is out and the pipeline is empty
	task automatic drain();
		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_direction(input logic d);
		src_valid <= 1'b0;
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_direction(d);
		settings++;
	endtask

	// random byte message for encode, ended on its last byte or by a bare end
	task automatic send_bytes();
		int n;
		bit on_byte;
		n = $urandom_range(0, 7);
		on_byte = (n != 0) && ($urandom_range(0, 1) == 1);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 7) == 0) send_item(1'b0, 8'($urandom), 1'b0);
			send_item(1'b1, 8'($urandom), on_byte && i == n - 1);
		end
		if (!on_byte) send_item(1'b0, 8'($urandom), 1'b1);
	endtask

	// random text for decode: mostly well-formed, some with a bad character,
	// an early pad or plain noise
	task automatic send_text();
		logic [7:0] txt[$];
		logic [7:0] bad;
		int kind;
		int n;
		bit on_char;
		kind = $urandom_range(0, 9);
		n = (kind == 8) ? $urandom_range(1, 8) : $urandom_range(0, 12);
		for (int i = 0; i < n; i++)
			txt = {txt, (kind == 8 ? 8'($urandom) :
				8'(tracker.alphabet[$urandom_range(0, 63)]))};
		if (kind <= 6) begin
			if (n % 4 == 2) begin
				txt = {txt, b64_pkg::CHAR_PAD};
				txt = {txt, b64_pkg::CHAR_PAD};
			end else if (n % 4 == 3) begin
				txt = {txt, b64_pkg::CHAR_PAD};
			end
		end else if (kind == 7) begin
			do bad = 8'($urandom);
			while (!tracker.char_val[bad][6] || bad == b64_pkg::CHAR_PAD);
			txt.insert($urandom_range(0, n), bad);
		end else if (kind == 9) begin
			txt.insert($urandom_range(0, n), b64_pkg::CHAR_PAD);
		end
		// characters after a stop must be ignored
		if (kind >= 7 || $urandom_range(0, 3) == 0) begin
			txt = {txt, 8'(tracker.alphabet[$urandom_range(0, 63)])};
			txt = {txt, 8'($urandom)};
		end
		on_char = (txt.size() != 0) && ($urandom_range(0, 1) == 1);
		for (int i = 0; i < txt.size(); i++) begin
			if ($urandom_range(0, 9) == 0) send_item(1'b0, 8'($urandom), 1'b0);
			send_item(1'b1, txt[i], on_char && i == txt.size() - 1);
		end
		if (!on_char) send_item(1'b0, 8'($urandom), 1'b1);
	endtask

	// whole messages until the count is reached, optionally an unfinished tail
	task automatic run_phase(input int target, input bit leave_partial);
		int start;
		int n;
		start = items_in;
		while (items_in - start < target) begin
			if (tracker.dir == b64_pkg::DIR_DECODE) send_text();
			else send_bytes();
		end
		if (leave_partial) begin
			n = $urandom_range(1, 5);
			for (int i = 0; i < n; i++)
				send_item(1'b1, tracker.dir == b64_pkg::DIR_DECODE ?
					8'(tracker.alphabet[$urandom_range(0, 63)]) : 8'($urandom), 1'b0);
		end
	endtask

	initial begin
		tracker = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// encode: full group, one and two byte tails, bare end, plus and slash
		write_direction(b64_pkg::DIR_ENCODE);
		send_string("Man", 1'b1);
		send_item(1'b1, 8'h00, 1'b1);
		send_item(1'b1, 8'hff, 1'b0);
		send_item(1'b1, 8'hff, 1'b1);
		send_item(1'b0, 8'h00, 1'b0);
		send_item(1'b0, 8'hff, 1'b1);
		send_item(1'b1, 8'hfb, 1'b0);
		send_item(1'b1, 8'hff, 1'b0);
		send_item(1'b1, 8'hbf, 1'b0);
		send_item(1'b0, 8'h00, 1'b1);

		// decode: full group, pad stop, dropped single char, invalid stop
		write_direction(b64_pkg::DIR_DECODE);
		send_string("TWFu", 1'b1);
		send_string("QQ=", 1'b1);
		send_string("Q", 1'b0);
		send_item(1'b0, 8'h00, 1'b1);
		send_string("+/*A", 1'b0);
		send_item(1'b0, 8'h00, 1'b1);
		send_item(1'b1, 8'hff, 1'b1);

		// random encode and decode phases, the first with a long output hold while the input keeps coming
		write_direction(b64_pkg::DIR_ENCODE);
		hold_req = 1'b1;
		burst_left = 40;
		run_phase(20, 1'b1);
		write_direction(b64_pkg::DIR_DECODE);
		run_phase(20, 1'b1);
		write_direction(b64_pkg::DIR_ENCODE);
		run_phase(8, 1'b0);
		write_direction(b64_pkg::DIR_DECODE);
		run_phase(8, 1'b0);

		src_valid <= 1'b0;
		drain();
		$display("covered %0d input items over %0d direction writes, %0d results checked",
			items_in, settings, tracker.checked);
		$display("encode and decode with padding, pad and invalid stops, bare ends, drops");
		if (tracker.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
